>>> rtl/core/shape_stability_ema_filter_defines.svh
// Assertion macros shared by the shape stability filter RTL.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef SHAPE_STABILITY_EMA_FILTER_DEFINES_SVH
`define SHAPE_STABILITY_EMA_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define SSEF_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
// A condition that must hold in the cycle after a trigger.
`define SSEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSEF_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define SSEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/ssef_pkg.sv
// Shared types and constants of the shape stability filter.
// No dependencies; the front end, back end, top level and testbench import it.
package ssef_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_NOISY  = 2'd0;
  localparam logic [1:0] FUNC_NORMAL = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Shape codes.
  localparam logic [1:0] KIND_BOX = 2'd0;

  // Configuration register indexes and widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WEAK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_STRONG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_NEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_NEED   = 3'd4;

  localparam int ALPHA_W   = 17;
  localparam int LIMIT_W   = 24;
  localparam int NEED_W    = 8;
  localparam int FRAC_BITS = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_WEAK_RST   = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_STRONG_RST = 17'd32768;
  localparam logic [LIMIT_W-1:0] VAR_LIMIT_RST    = 24'd6554;
  localparam logic [NEED_W-1:0]  STREAK_NEED_RST  = 8'd3;
  localparam logic [NEED_W-1:0]  NOISY_NEED_RST   = 8'd3;

  // Normal-measurement break counter: saturates at three, drops the run at two.
  localparam logic [1:0] BREAK_MAX  = 2'd3;
  localparam logic [1:0] BREAK_DROP = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  // Operation class assigned by the front end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_NOISY_BOX,
    OP_NOISY_OTHER,
    OP_NORMAL,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
  } ctrl_t;

endpackage

>>> rtl/core/ssef_in_if.sv
// Input channel of the shape stability filter: valid/ready plus one measurement.
// No dependencies.
interface ssef_in_if #(
  parameter int DIM_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [1:0]          shape_kind;
  logic [DIM_BITS-1:0] dim_length;
  logic [DIM_BITS-1:0] dim_width;
  logic [DIM_BITS-1:0] dim_height;

  modport source (
    output valid, func, shape_kind, dim_length, dim_width, dim_height,
    input  ready
  );
  modport sink (
    input  valid, func, shape_kind, dim_length, dim_width, dim_height,
    output ready
  );
endinterface

>>> rtl/core/ssef_out_if.sv
// Result channel of the shape stability filter: valid/ready plus one reported shape.
// No dependencies.
interface ssef_out_if #(
  parameter int DIM_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [1:0]          out_kind;
  logic [DIM_BITS-1:0] out_length;
  logic [DIM_BITS-1:0] out_width;
  logic [DIM_BITS-1:0] out_height;
  logic                is_smoothed;

  modport source (
    output valid, out_kind, out_length, out_width, out_height, is_smoothed,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_length, out_width, out_height, is_smoothed,
    output ready
  );
endinterface

>>> rtl/core/ssef_front.sv
// Front end: takes input transactions and classifies them into operations.
// Depends on ssef_pkg and ssef_in_if.
module ssef_front import ssef_pkg::*; #(
  parameter  int DIM_BITS = 24,
  localparam int DATA_W   = $bits(ctrl_t) + 3 * DIM_BITS
) (
  ssef_in_if.sink           in_ch_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output logic [DATA_W-1:0] q_data_o
);

  ctrl_t ctrl;

  always_comb begin
    ctrl.kind = in_ch_i.shape_kind;
    unique case (in_ch_i.func)
      FUNC_NOISY:  ctrl.op = (in_ch_i.shape_kind == KIND_BOX) ? OP_NOISY_BOX : OP_NOISY_OTHER;
      FUNC_NORMAL: ctrl.op = OP_NORMAL;
      FUNC_CLEAR:  ctrl.op = OP_CLEAR;
      default:     ctrl.op = OP_NONE;
    endcase
  end

  assign in_ch_i.ready = q_ready_i;
  assign q_push_o      = in_ch_i.valid & q_ready_i;
  assign q_data_o      = {ctrl, in_ch_i.dim_height, in_ch_i.dim_width, in_ch_i.dim_length};

endmodule

>>> rtl/core/ssef_queue.sv
// Small FIFO that decouples the front end from the back end.
// Depends on the assertion macros header.
`include "shape_stability_ema_filter_defines.svh"
module ssef_queue #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  `SSEF_ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push_i && !ready_o))
  `SSEF_ASSERT_ALWAYS(a_no_underflow, clk_i, rst_ni, !(pop_i && !valid_o))
  `SSEF_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))

endmodule

>>> rtl/core/ssef_back.sv
// Back end: holds configuration and filter state, applies one operation per cycle
// unless stalled, registers the result; depends on ssef_pkg, ssef_out_if, macros.
`include "shape_stability_ema_filter_defines.svh"
module ssef_back import ssef_pkg::*; #(
  parameter  int DIM_BITS   = 24,
  parameter  int COUNT_BITS = 8,
  localparam int DATA_W     = $bits(ctrl_t) + 3 * DIM_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_valid_i,
  input  logic [DATA_W-1:0]     q_data_i,
  output logic                  q_pop_o,
  ssef_out_if.source            res_o
);

  localparam int PROD_W = DIM_BITS + ALPHA_W;
  localparam int CONV_W = DIM_BITS + LIMIT_W;
  localparam int NCMP_W = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;

  // Floor-shifted EMA step with saturation to the dimension range.
  function automatic logic [DIM_BITS-1:0] ema_step(input logic [DIM_BITS-1:0] v,
                                                   input logic [DIM_BITS-1:0] m,
                                                   input logic [ALPHA_W-1:0]  a);
    logic [DIM_BITS-1:0] diff;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     rnd;
    logic [DIM_BITS+1:0] sum;
    logic [DIM_BITS+1:0] dec;
    logic [DIM_BITS-1:0] res;
    diff = (m >= v) ? m - v : v - m;
    prod = PROD_W'(a) * PROD_W'(diff);
    rnd  = (PROD_W + 1)'(prod) + (PROD_W + 1)'((1 << FRAC_BITS) - 1);
    sum  = (DIM_BITS + 2)'(v) + (DIM_BITS + 2)'(prod[PROD_W-1:FRAC_BITS]);
    dec  = rnd[PROD_W:FRAC_BITS];
    if (m >= v) begin
      res = (sum[DIM_BITS+1:DIM_BITS] != 2'b00) ? '1 : sum[DIM_BITS-1:0];
    end else begin
      res = (dec >= (DIM_BITS + 2)'(v)) ? '0 : v - dec[DIM_BITS-1:0];
    end
    return res;
  endfunction

  // Relative deviation test with the divisor floored at one LSB.
  function automatic logic axis_conv(input logic [DIM_BITS-1:0] v,
                                     input logic [DIM_BITS-1:0] m,
                                     input logic [LIMIT_W-1:0]  lim);
    logic [DIM_BITS-1:0] d;
    logic [DIM_BITS-1:0] f;
    d = (m >= v) ? m - v : v - m;
    f = (v == '0) ? DIM_BITS'(1) : v;
    return CONV_W'({d, {FRAC_BITS{1'b0}}}) < (CONV_W'(lim) * CONV_W'(f));
  endfunction

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha_weak_q, alpha_strong_q;
  logic [LIMIT_W-1:0] var_limit_q;
  logic [NEED_W-1:0]  streak_need_q, noisy_need_q;

  // Filter state.
  logic [2:0][DIM_BITS-1:0] smooth_q, smooth_d;
  logic [2:0][DIM_BITS-1:0] latest_q, latest_d;
  logic [1:0]               latest_kind_q, latest_kind_d;
  logic                     has_estimate_q, has_estimate_d;
  logic                     is_stable_q, is_stable_d;
  logic [COUNT_BITS-1:0]    streak_q, streak_d;
  logic [COUNT_BITS-1:0]    run_q, run_d;
  logic [1:0]               breaks_q, breaks_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               out_kind_q;
  logic [2:0][DIM_BITS-1:0] out_dims_q;
  logic                     out_smooth_q;

  ctrl_t                    ctrl;
  logic [2:0][DIM_BITS-1:0] meas;
  logic [2:0][DIM_BITS-1:0] ema_strong, ema_weak;
  logic [2:0]               conv;
  logic                     pop;

  assign ctrl = ctrl_t'(q_data_i[DATA_W-1 -: $bits(ctrl_t)]);
  assign meas = q_data_i[3*DIM_BITS-1:0];

  assign pop     = q_valid_i & (~out_valid_q | res_o.ready);
  assign q_pop_o = pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      conv[i]       = axis_conv(smooth_q[i], meas[i], var_limit_q);
      ema_strong[i] = ema_step(smooth_q[i], meas[i], alpha_strong_q);
      ema_weak[i]   = ema_step(smooth_q[i], meas[i], alpha_weak_q);
    end
  end

  always_comb begin
    smooth_d       = smooth_q;
    latest_d       = latest_q;
    latest_kind_d  = latest_kind_q;
    has_estimate_d = has_estimate_q;
    is_stable_d    = is_stable_q;
    streak_d       = streak_q;
    run_d          = run_q;
    breaks_d       = breaks_q;
    if (pop) begin
      unique case (ctrl.op)
        OP_NOISY_BOX: begin
          if (!has_estimate_q) begin
            smooth_d       = meas;
            has_estimate_d = 1'b1;
            is_stable_d    = 1'b0;
            streak_d       = '0;
          end else begin
            run_d    = (run_q == '1) ? run_q : run_q + 1'b1;
            breaks_d = '0;
            if (&conv) begin
              smooth_d = ema_strong;
              streak_d = (streak_q == '1) ? streak_q : streak_q + 1'b1;
              if ((NCMP_W'(streak_d) >= NCMP_W'(streak_need_q)) &&
                  (NCMP_W'(run_d) >= NCMP_W'(noisy_need_q))) begin
                is_stable_d = 1'b1;
              end
            end else begin
              smooth_d    = ema_weak;
              streak_d    = '0;
              is_stable_d = 1'b0;
            end
          end
        end
        OP_NOISY_OTHER: begin
          is_stable_d   = 1'b0;
          latest_kind_d = ctrl.kind;
          latest_d      = meas;
        end
        OP_NORMAL: begin
          latest_kind_d = ctrl.kind;
          latest_d      = meas;
          breaks_d      = (breaks_q == BREAK_MAX) ? breaks_q : breaks_q + 1'b1;
          if (breaks_d >= BREAK_DROP) begin
            run_d       = '0;
            is_stable_d = 1'b0;
          end
        end
        OP_CLEAR: begin
          has_estimate_d = 1'b0;
          is_stable_d    = 1'b0;
          streak_d       = '0;
          run_d          = '0;
          breaks_d       = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_weak_q   <= ALPHA_WEAK_RST;
      alpha_strong_q <= ALPHA_STRONG_RST;
      var_limit_q    <= VAR_LIMIT_RST;
      streak_need_q  <= STREAK_NEED_RST;
      noisy_need_q   <= NOISY_NEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA_WEAK:   alpha_weak_q   <= cfg_data_i[ALPHA_W-1:0];
        CFG_ALPHA_STRONG: alpha_strong_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_VAR_LIMIT:    var_limit_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_STREAK_NEED:  streak_need_q  <= cfg_data_i[NEED_W-1:0];
        CFG_NOISY_NEED:   noisy_need_q   <= cfg_data_i[NEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q       <= '0;
      latest_kind_q  <= KIND_BOX;
      has_estimate_q <= 1'b0;
      is_stable_q    <= 1'b0;
      streak_q       <= '0;
      run_q          <= '0;
      breaks_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      latest_q       <= latest_d;
      latest_kind_q  <= latest_kind_d;
      has_estimate_q <= has_estimate_d;
      is_stable_q    <= is_stable_d;
      streak_q       <= streak_d;
      run_q          <= run_d;
      breaks_q       <= breaks_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // The smoothed vector is loaded by the first noisy box and needs no reset.
  always_ff @(posedge clk_i) begin
    smooth_q <= smooth_d;
    if (pop) begin
      out_kind_q   <= is_stable_d ? KIND_BOX : latest_kind_d;
      out_dims_q   <= is_stable_d ? smooth_d : latest_d;
      out_smooth_q <= is_stable_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_kind    = out_kind_q;
  assign res_o.out_length  = out_dims_q[0];
  assign res_o.out_width   = out_dims_q[1];
  assign res_o.out_height  = out_dims_q[2];
  assign res_o.is_smoothed = out_smooth_q;

  `SSEF_ASSERT_ALWAYS(a_stable_needs_estimate, clk_i, rst_ni, !is_stable_q || has_estimate_q)
  `SSEF_ASSERT_NEXT(a_clear_drops_state, clk_i, rst_ni, pop && (ctrl.op == OP_CLEAR),
                    !has_estimate_q && !is_stable_q && (run_q == '0))
  `SSEF_ASSERT_NEXT(a_smoothed_flag_matches, clk_i, rst_ni, pop,
                    out_valid_q && (out_smooth_q == is_stable_q))

endmodule

>>> rtl/core/shape_stability_ema_filter.sv
// Top level of the shape stability filter: front end, decoupling queue, back end.
// Depends on ssef_pkg, ssef_in_if, ssef_out_if, ssef_front, ssef_queue and ssef_back.

// The filter takes one measurement transaction per clock cycle on in_ch_i while
// the queue has room and returns exactly one result transaction per measurement
// on res_o, in order. On its way a result passes the two-entry queue between the
// front and back ends and then the back end's output register. The sustained
// rate of one item per cycle while res_o does not stall is set by the back end's
// state update, which completes in a single registered step: the three per-axis
// deviation multipliers and both candidate EMA products (strong and weak gain)
// are computed side by side, and the converge decision only selects between
// them. The front end keeps accepting while a finished result waits on a
// stalled res_o, until the queue fills. The smoothed box is loaded by the first
// noisy box measurement after reset or a clear and has no reset value of its own.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i take effect at the next
// edge and must be issued only while no transaction is in flight; indexes past
// the last register are ignored.
module shape_stability_ema_filter import ssef_pkg::*; #(
  parameter int DIM_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssef_in_if.sink               in_ch_i,
  ssef_out_if.source            res_o
);

  localparam int DATA_W = $bits(ctrl_t) + 3 * DIM_BITS;

  // Queue handshake between the two halves.
  logic              push;
  logic              q_ready;
  logic [DATA_W-1:0] push_data;
  logic              q_valid;
  logic              pop;
  logic [DATA_W-1:0] pop_data;

  // The front end only decodes; it pushes each valid input whenever the queue has room.
  ssef_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .in_ch_i   (in_ch_i),
    .q_ready_i (q_ready),
    .q_push_o  (push),
    .q_data_o  (push_data)
  );

  ssef_queue #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  // The back end pops when its output register is free or being drained.
  ssef_back #(
    .DIM_BITS   (DIM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .res_o      (res_o)
  );

endmodule

>>> dv/ssef_filter_check.sv
// Scoreboard of the shape stability filter: tracks configuration writes, predicts
// one reported shape per accepted measurement and compares results in order.
// Depends on ssef_pkg, ssef_in_if and ssef_out_if.
module ssef_filter_check import ssef_pkg::*; #(
  parameter int DIM_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssef_in_if                    meas_mon_i,
  ssef_out_if                   report_mon_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    smoothed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DIM_MAX = (64'd1 << DIM_BITS) - 64'd1;
  localparam longint unsigned ROUND_UP = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [DIM_BITS-1:0] len;
    logic [DIM_BITS-1:0] wid;
    logic [DIM_BITS-1:0] hgt;
    logic                smoothed;
  } shape_report_t;

  logic [ALPHA_W-1:0]    gain_weak;
  logic [ALPHA_W-1:0]    gain_strong;
  logic [LIMIT_W-1:0]    dev_limit;
  logic [NEED_W-1:0]     streak_goal;
  logic [NEED_W-1:0]     run_goal;

  logic [DIM_BITS-1:0]   smoothed_dims [3];
  logic [DIM_BITS-1:0]   latest_dims [3];
  logic [1:0]            latest_kind;
  bit                    has_estimate;
  bit                    stable;
  logic [COUNT_BITS-1:0] streak;
  logic [COUNT_BITS-1:0] noisy_run;
  logic [1:0]            breaks;

  shape_report_t expected_reports [$];
  int mismatches;
  int checked;
  int smoothed_count;

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] result %0d: %s expected %h got %h", $realtime, checked, what, want, got);
    mismatches++;
  endtask

  // Moves v toward m by gain/65536 of the gap, rounding toward minus infinity and
  // clamping to the dimension range when the gain extrapolates.
  function automatic logic [DIM_BITS-1:0] ema_blend(logic [DIM_BITS-1:0] v,
                                                    logic [DIM_BITS-1:0] m,
                                                    logic [ALPHA_W-1:0] gain);
    longint unsigned vv, mm, aa, step;
    vv = v;
    mm = m;
    aa = gain;
    if (mm >= vv) begin
      step = vv + ((aa * (mm - vv)) >> FRAC_BITS);
      return DIM_BITS'((step > DIM_MAX) ? DIM_MAX : step);
    end
    step = (aa * (vv - mm) + ROUND_UP) >> FRAC_BITS;
    return DIM_BITS'((step >= vv) ? 64'd0 : vv - step);
  endfunction

  // Relative deviation test without a division; a zero estimate counts as one LSB.
  function automatic bit axis_settles(logic [DIM_BITS-1:0] v, logic [DIM_BITS-1:0] m);
    longint unsigned vv, mm, gap, lim;
    vv = v;
    mm = m;
    lim = dev_limit;
    gap = (mm >= vv) ? mm - vv : vv - mm;
    if (vv == 0)
      vv = 1;
    return (gap << FRAC_BITS) < lim * vv;
  endfunction

  function automatic shape_report_t predict_report(logic [1:0] fn, logic [1:0] kind,
                                                   logic [DIM_BITS-1:0] meas [3]);
    shape_report_t rep;
    bit settles;
    logic [ALPHA_W-1:0] gain;
    case (fn)
      FUNC_NOISY: begin
        if (kind != KIND_BOX) begin
          stable = 1'b0;
          latest_kind = kind;
          for (int i = 0; i < 3; i++) latest_dims[i] = meas[i];
        end else if (!has_estimate) begin
          for (int i = 0; i < 3; i++) smoothed_dims[i] = meas[i];
          has_estimate = 1'b1;
          stable = 1'b0;
          streak = '0;
        end else begin
          if (noisy_run != COUNT_MAX) noisy_run++;
          breaks = '0;
          settles = 1'b1;
          for (int i = 0; i < 3; i++)
            if (!axis_settles(smoothed_dims[i], meas[i])) settles = 1'b0;
          gain = settles ? gain_strong : gain_weak;
          for (int i = 0; i < 3; i++)
            smoothed_dims[i] = ema_blend(smoothed_dims[i], meas[i], gain);
          if (settles) begin
            if (streak != COUNT_MAX) streak++;
            if (streak >= streak_goal && noisy_run >= run_goal) stable = 1'b1;
          end else begin
            streak = '0;
            stable = 1'b0;
          end
        end
      end
      FUNC_NORMAL: begin
        latest_kind = kind;
        for (int i = 0; i < 3; i++) latest_dims[i] = meas[i];
        if (breaks != BREAK_MAX) breaks++;
        if (breaks >= BREAK_DROP) begin
          noisy_run = '0;
          stable = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        has_estimate = 1'b0;
        stable = 1'b0;
        streak = '0;
        noisy_run = '0;
        breaks = '0;
      end
      default: ;
    endcase
    if (stable)
      rep = '{kind: KIND_BOX, len: smoothed_dims[0], wid: smoothed_dims[1],
              hgt: smoothed_dims[2], smoothed: 1'b1};
    else
      rep = '{kind: latest_kind, len: latest_dims[0], wid: latest_dims[1],
              hgt: latest_dims[2], smoothed: 1'b0};
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    shape_report_t got;
    shape_report_t want;
    logic [DIM_BITS-1:0] meas [3];
    if (!rst_ni) begin
      gain_weak = ALPHA_WEAK_RST;
      gain_strong = ALPHA_STRONG_RST;
      dev_limit = VAR_LIMIT_RST;
      streak_goal = STREAK_NEED_RST;
      run_goal = NOISY_NEED_RST;
      for (int i = 0; i < 3; i++) begin
        smoothed_dims[i] = '0;
        latest_dims[i] = '0;
      end
      latest_kind = KIND_BOX;
      has_estimate = 1'b0;
      stable = 1'b0;
      streak = '0;
      noisy_run = '0;
      breaks = '0;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALPHA_WEAK:   gain_weak = cfg_data_i[ALPHA_W-1:0];
          CFG_ALPHA_STRONG: gain_strong = cfg_data_i[ALPHA_W-1:0];
          CFG_VAR_LIMIT:    dev_limit = cfg_data_i[LIMIT_W-1:0];
          CFG_STREAK_NEED:  streak_goal = cfg_data_i[NEED_W-1:0];
          CFG_NOISY_NEED:   run_goal = cfg_data_i[NEED_W-1:0];
          default: ;
        endcase
      end
      // Results are checked before the measurement of the same edge is predicted,
      // since a result can never belong to a measurement accepted at its own edge.
      if (report_mon_i.valid && report_mon_i.ready) begin
        got = '{kind: report_mon_i.out_kind, len: report_mon_i.out_length,
                wid: report_mon_i.out_width, hgt: report_mon_i.out_height,
                smoothed: report_mon_i.is_smoothed};
        checked++;
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected result, kind", '0, 32'(got.kind));
        end else begin
          want = expected_reports.pop_front();
          if (want.smoothed) smoothed_count++;
          if (got.kind !== want.kind)
            flag_mismatch("out_kind", 32'(want.kind), 32'(got.kind));
          if (got.len !== want.len)
            flag_mismatch("out_length", 32'(want.len), 32'(got.len));
          if (got.wid !== want.wid)
            flag_mismatch("out_width", 32'(want.wid), 32'(got.wid));
          if (got.hgt !== want.hgt)
            flag_mismatch("out_height", 32'(want.hgt), 32'(got.hgt));
          if (got.smoothed !== want.smoothed)
            flag_mismatch("is_smoothed", 32'(want.smoothed), 32'(got.smoothed));
        end
      end
      if (meas_mon_i.valid && meas_mon_i.ready) begin
        meas[0] = meas_mon_i.dim_length;
        meas[1] = meas_mon_i.dim_width;
        meas[2] = meas_mon_i.dim_height;
        expected_reports.push_back(predict_report(meas_mon_i.func, meas_mon_i.shape_kind,
                                                  meas));
      end
      pending_o <= expected_reports.size();
    end
    fail_count_o <= mismatches;
    checked_o <= checked;
    smoothed_o <= smoothed_count;
  end

endmodule

>>> dv/testbench.sv
// Top of the shape stability filter testbench: clock, reset, stimulus, verdict.
// Depends on ssef_pkg, ssef_in_if, ssef_out_if, ssef_filter_check and the filter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssef_pkg::*;

  localparam int DIM_BITS   = 24;
  localparam int COUNT_BITS = 8;

  // Shape and function codes that the package does not name.
  localparam logic [1:0] KIND_CYLINDER = 2'd1;
  localparam logic [1:0] KIND_POLYGON  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;
  localparam logic [1:0] FUNC_SPARE    = 2'd3;

  // First register index past the list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_NOISY_NEED + 1'b1;

  localparam logic [DIM_BITS-1:0] DIM_ALL   = '1;
  localparam logic [ALPHA_W-1:0]  ALPHA_ALL = '1;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;
  localparam logic [LIMIT_W-1:0]  LIMIT_ALL = '1;
  localparam logic [NEED_W-1:0]   NEED_ALL  = '1;

  // Cycles without any transaction on either channel before the run is abandoned.
  // The slowest legal stretch is a long receiver stall at 88 percent idling plus a
  // block of configuration writes.
  localparam int STALL_LIMIT = 4000;
  // Cycles to wait after the last result, with plenty of margin.
  localparam int TAIL_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int smoothed_seen;

  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int settings_used;

  ssef_in_if  #(.DIM_BITS(DIM_BITS)) meas_ch ();
  ssef_out_if #(.DIM_BITS(DIM_BITS)) report_ch ();

  shape_stability_ema_filter #(
    .DIM_BITS  (DIM_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_ch_i   (meas_ch),
    .res_o     (report_ch)
  );

  // The scoreboard sits beside the block and only watches its ports.
  ssef_filter_check #(
    .DIM_BITS  (DIM_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_filter_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .meas_mon_i  (meas_ch),
    .report_mon_i(report_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .smoothed_o  (smoothed_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side back-pressure. Ready is redrawn every cycle, so a stall can land
  // on any stage of the pipeline, including while the queue is full.
  initial begin
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      report_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog: any cycle with a transaction on either channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((meas_ch.valid && meas_ch.ready) || (report_ch.valid && report_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results still owed", quiet, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one measurement and returns at the edge where it is accepted. The
  // optional gap before it keeps valid low for a random number of cycles.
  task automatic push_item(logic [1:0] fn, logic [1:0] kind, logic [DIM_BITS-1:0] len,
                           logic [DIM_BITS-1:0] wid, logic [DIM_BITS-1:0] hgt);
    if ($urandom_range(99) < in_idle_pct) begin
      meas_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    meas_ch.valid      <= 1'b1;
    meas_ch.func       <= fn;
    meas_ch.shape_kind <= kind;
    meas_ch.dim_length <= len;
    meas_ch.dim_width  <= wid;
    meas_ch.dim_height <= hgt;
    do @(posedge clk); while (!meas_ch.ready);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has been taken. The first
  // edge is always waited out so that the count reflects the last transaction.
  task automatic drain();
    meas_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes all five registers back to back, plus one write to an unused index,
  // and only then drops the write enable.
  task automatic load_settings(logic [ALPHA_W-1:0] weak_gain, logic [ALPHA_W-1:0] strong_gain,
                               logic [LIMIT_W-1:0] limit, logic [NEED_W-1:0] streak_goal,
                               logic [NEED_W-1:0] run_goal);
    cfg_write(CFG_ALPHA_WEAK, CFG_DATA_W'(weak_gain));
    cfg_write(CFG_ALPHA_STRONG, CFG_DATA_W'(strong_gain));
    cfg_write(CFG_VAR_LIMIT, CFG_DATA_W'(limit));
    cfg_write(CFG_STREAK_NEED, CFG_DATA_W'(streak_goal));
    cfg_write(CFG_NOISY_NEED, CFG_DATA_W'(run_goal));
    cfg_write(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Dimension values skewed toward the corners: zero, full scale, a few LSBs and
  // single set bits, with plain random values for the rest.
  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return DIM_ALL;
      2: return DIM_BITS'($urandom_range(4));
      3: return DIM_BITS'(1) << $urandom_range(DIM_BITS - 1);
      default: return DIM_BITS'($urandom);
    endcase
  endfunction

  // A measurement scattered around base by a random fraction of it, so that
  // both sides of the deviation limit are reached; now and then a wild value.
  function automatic logic [DIM_BITS-1:0] jitter(logic [DIM_BITS-1:0] base);
    longint unsigned b, span, off;
    if ($urandom_range(9) == 0)
      return pick_dim();
    b = base;
    span = b >> $urandom_range(2, 10);
    off = $urandom_range(0, int'(span));
    if ($urandom_range(1))
      return DIM_BITS'((b + off > DIM_ALL) ? DIM_ALL : b + off);
    return DIM_BITS'((off > b) ? 0 : b - off);
  endfunction

  // Mostly tracks: a run of noisy boxes around one true shape, with the odd
  // normal measurement or other shape type mixed in, sometimes after a clear.
  // The remainder is unstructured noise over every function and shape code.
  task automatic random_traffic(int count);
    int stop_at;
    int run_len;
    int pick;
    logic [DIM_BITS-1:0] track [3];
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 65) begin
        if ($urandom_range(9) == 0)
          push_item(FUNC_CLEAR, KIND_BOX, pick_dim(), pick_dim(), pick_dim());
        for (int i = 0; i < 3; i++) track[i] = pick_dim();
        run_len = $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          pick = $urandom_range(19);
          if (pick == 0)
            push_item(FUNC_NORMAL, 2'($urandom_range(KIND_BOX, KIND_UNKNOWN)),
                      pick_dim(), pick_dim(), pick_dim());
          else if (pick == 1)
            push_item(FUNC_NOISY, 2'($urandom_range(KIND_CYLINDER, KIND_UNKNOWN)),
                      pick_dim(), pick_dim(), pick_dim());
          else
            push_item(FUNC_NOISY, KIND_BOX, jitter(track[0]), jitter(track[1]),
                      jitter(track[2]));
        end
      end else begin
        push_item(2'($urandom_range(FUNC_NOISY, FUNC_SPARE)),
                  2'($urandom_range(KIND_BOX, KIND_UNKNOWN)),
                  pick_dim(), pick_dim(), pick_dim());
      end
    end
  endtask

  initial begin : stimulus
    logic [DIM_BITS-1:0] base [3];
    rst_n        = 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_ALPHA_WEAK;
    cfg_data     <= '0;
    meas_ch.valid      <= 1'b0;
    meas_ch.func       <= FUNC_NOISY;
    meas_ch.shape_kind <= KIND_BOX;
    meas_ch.dim_length <= '0;
    meas_ch.dim_width  <= '0;
    meas_ch.dim_height <= '0;
    in_idle_pct  = 19;
    out_idle_pct = 88;
    items_sent   = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: gains one half and one tenth, a ten
    // percent limit, three converging boxes and three noisy boxes to stabilize.
    // An unused function code on the fresh filter only reports the reset shape.
    push_item(FUNC_SPARE, KIND_UNKNOWN, DIM_ALL, DIM_ALL, DIM_ALL);
    // Noisy shapes other than a box, including the unknown code, become the latest.
    push_item(FUNC_NOISY, KIND_CYLINDER, DIM_ALL, '0, DIM_ALL);
    push_item(FUNC_NOISY, KIND_UNKNOWN, '0, DIM_ALL, '0);
    // The first box loads the estimate; three near copies make it stable.
    push_item(FUNC_NOISY, KIND_BOX, 24'd2048, 24'd1536, 24'd4096);
    repeat (3) push_item(FUNC_NOISY, KIND_BOX, 24'd2060, 24'd1530, 24'd4096);
    // A polygon drops stability; the streak and run carry on, so the next
    // converging box makes it stable again at once.
    push_item(FUNC_NOISY, KIND_POLYGON, 24'd777, 24'd888, 24'd999);
    repeat (3) push_item(FUNC_NOISY, KIND_BOX, 24'd2040, 24'd1540, 24'd4100);
    // A box far off takes the weak gain and loses stability.
    push_item(FUNC_NOISY, KIND_BOX, 24'd8000, 24'd100, 24'd4100);
    // Three normal measurements in a row: the second ends the run, the third
    // leaves the break counter saturated.
    push_item(FUNC_NORMAL, KIND_BOX, 24'd1000, 24'd1000, 24'd1000);
    push_item(FUNC_NORMAL, KIND_CYLINDER, 24'd500, 24'd500, 24'd1500);
    push_item(FUNC_NORMAL, KIND_POLYGON, DIM_ALL, DIM_ALL, DIM_ALL);
    // Clear, then an all-zero estimate where the deviation floor of one LSB applies.
    push_item(FUNC_CLEAR, KIND_UNKNOWN, '0, '0, '0);
    push_item(FUNC_NOISY, KIND_BOX, '0, '0, '0);
    push_item(FUNC_NOISY, KIND_BOX, '0, '0, '0);
    push_item(FUNC_NOISY, KIND_BOX, 24'd1, '0, '0);
    push_item(FUNC_NOISY, KIND_BOX, DIM_ALL, DIM_ALL, DIM_ALL);
    push_item(FUNC_SPARE, KIND_BOX, '0, '0, '0);
    push_item(FUNC_CLEAR, KIND_BOX, DIM_ALL, DIM_ALL, DIM_ALL);
    random_traffic(240);
    drain();

    // Extreme gains and the widest limit: nearly every box converges and the strong
    // gain nearly doubles each step, so results clip at both ends. One long track
    // pushes the streak and the noisy run into saturation.
    in_idle_pct  = 88;
    out_idle_pct = 19;
    load_settings('0, ALPHA_ALL, LIMIT_ALL, '0, '0);
    push_item(FUNC_CLEAR, KIND_BOX, '0, '0, '0);
    for (int i = 0; i < 3; i++) base[i] = DIM_BITS'($urandom_range(1024, 1 << 20));
    repeat (300)
      push_item(FUNC_NOISY, KIND_BOX, jitter(base[0]), jitter(base[1]), jitter(base[2]));
    random_traffic(100);
    drain();

    // Zero limit: no box ever converges, and both goals sit at their maximum.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    load_settings(ALPHA_ONE, '0, '0, NEED_ALL, NEED_ALL);
    random_traffic(80);
    drain();

    // A few random settings around the useful range.
    repeat (3) begin
      load_settings(ALPHA_W'($urandom_range(0, ALPHA_ALL)),
                    ALPHA_W'($urandom_range(0, ALPHA_ALL)),
                    LIMIT_W'($urandom_range(0, 24'h040000)),
                    NEED_W'($urandom_range(0, 6)),
                    NEED_W'($urandom_range(0, 6)));
      random_traffic(120);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d measurements under %0d register settings after the reset values.",
             items_sent, settings_used);
    $display("Checked %0d results, %0d of them stable smoothed boxes; %0d mismatches.",
             checked, smoothed_seen, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
